@@ rtl/ppd_pkg.sv @@
// Shared types and constants for the polyline point densifier.
// Used by ppd_ctrl, ppd_datapath, the top level and the checker; no dependencies.
package ppd_pkg;

    localparam int COORD_BITS     = 24;
    localparam int MAX_INSERT_DEF = 63;
    localparam int MAXN_W         = 6;
    localparam int SPC_W          = 24;
    localparam int SEG_W          = 24;
    localparam int PATH_W         = 40;
    localparam int CFG_W          = 24;
    localparam int CFG_IDX_W      = 1;

    // Magnitude of a coordinate difference, its square and its square root.
    localparam int MAG_W   = COORD_BITS + 1;
    localparam int SQ_W    = 2 * MAG_W;
    localparam int SQRT_IT = MAG_W;
    localparam int LEN_W   = MAG_W;
    localparam int RT_W    = LEN_W + 2;
    localparam int ACC_W   = ((LEN_W > SPC_W) ? LEN_W : SPC_W) + 1;
    localparam int DV_W    = LEN_W + 2;

    localparam logic [CFG_IDX_W-1:0] CFG_INSERT_MAX = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPACING    = 1'd1;

    localparam logic [MAXN_W-1:0] INSERT_MAX_RST  = 6'd8;
    localparam logic [SPC_W-1:0]  SPACING_RST     = 24'd2560;
    localparam logic [SEG_W-1:0]  SEG_MAX         = {SEG_W{1'b1}};
    localparam logic [PATH_W-1:0] PATH_MAX        = {PATH_W{1'b1}};

    typedef struct packed {
        logic signed [COORD_BITS-1:0] x_coord;
        logic signed [COORD_BITS-1:0] y_coord;
    } t_in_word;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] out_x;
        logic signed [COORD_BITS-1:0] out_y;
        logic [SEG_W-1:0]             segment_length;
        logic [PATH_W-1:0]            path_length;
        logic                         last_of_run;
    } t_out_word;

    typedef enum logic [1:0] {
        DIV_X,
        DIV_Y,
        DIV_S
    } t_div_sel;

    typedef struct packed {
        logic     load;
        logic     first;
        logic     sq_x;
        logic     sq_y;
        logic     sq_sum;
        logic     sqrt_step;
        logic     cnt_init;
        logic     cnt_step;
        logic     div_init;
        logic     div_step;
        logic     div_store;
        t_div_sel div_sel;
        logic     emit_init;
        logic     emit;
    } t_cmd;

    typedef struct packed {
        logic have_prev;
        logic dup;
        logic cnt_done;
        logic emit_last;
        logic out_free;
    } t_status;

endpackage

@@ rtl/ppd_ctrl.sv @@
// Sequencing state machine of the polyline point densifier.
// Depends on ppd_pkg; drives the command word of ppd_datapath.
module ppd_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  ppd_pkg::t_status i_status,
    output ppd_pkg::t_cmd    o_cmd
);

    localparam int CW = $clog2(ppd_pkg::DV_W + 1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_SQX,
        S_SQY,
        S_SQS,
        S_SQRT,
        S_CNTI,
        S_CNT,
        S_DINI,
        S_DIV,
        S_DFIN,
        S_EINI,
        S_EMIT
    } t_state;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_cnt, n_cnt;
    ppd_pkg::t_div_sel r_sel, n_sel;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_sel   = r_sel;
        o_cmd   = '0;
        o_cmd.div_sel = r_sel;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_CHECK;
                end
            end
            S_CHECK: begin
                if (!i_status.have_prev) begin
                    o_cmd.first = 1'b1;
                    n_state     = S_EINI;
                end else if (i_status.dup) begin
                    n_state = S_IDLE;
                end else begin
                    n_state = S_SQX;
                end
            end
            S_SQX: begin
                o_cmd.sq_x = 1'b1;
                n_state    = S_SQY;
            end
            S_SQY: begin
                o_cmd.sq_y = 1'b1;
                n_state    = S_SQS;
            end
            S_SQS: begin
                o_cmd.sq_sum = 1'b1;
                n_cnt        = CW'(ppd_pkg::SQRT_IT - 1);
                n_state      = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.sqrt_step = 1'b1;
                n_cnt           = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_CNTI;
                end
            end
            S_CNTI: begin
                o_cmd.cnt_init = 1'b1;
                n_state        = S_CNT;
            end
            S_CNT: begin
                if (i_status.cnt_done) begin
                    n_sel   = ppd_pkg::DIV_X;
                    n_state = S_DINI;
                end else begin
                    o_cmd.cnt_step = 1'b1;
                end
            end
            S_DINI: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = CW'(ppd_pkg::DV_W - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_DFIN;
                end
            end
            S_DFIN: begin
                o_cmd.div_store = 1'b1;
                case (r_sel)
                    ppd_pkg::DIV_X: begin
                        n_sel   = ppd_pkg::DIV_Y;
                        n_state = S_DINI;
                    end
                    ppd_pkg::DIV_Y: begin
                        n_sel   = ppd_pkg::DIV_S;
                        n_state = S_DINI;
                    end
                    default: begin
                        n_state = S_EINI;
                    end
                endcase
            end
            S_EINI: begin
                o_cmd.emit_init = 1'b1;
                n_state         = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.emit_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_sel   <= ppd_pkg::DIV_X;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_sel   <= n_sel;
        end
    end

endmodule

@@ rtl/ppd_datapath.sv @@
// Datapath of the polyline point densifier: configuration, point state, squarer,
// bit-serial square root and divider, interpolation stepper and output register.
// Depends on ppd_pkg; controlled by ppd_ctrl.
module ppd_datapath #(
    parameter int MAX_INSERT = ppd_pkg::MAX_INSERT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [ppd_pkg::CFG_W-1:0]       i_cfg_wdata,
    input  ppd_pkg::t_in_word               i_in_word,
    input  ppd_pkg::t_cmd                   i_cmd,
    output ppd_pkg::t_status                o_status,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ppd_pkg::t_out_word              o_out_word
);

    localparam int CB   = ppd_pkg::COORD_BITS;
    localparam int MW   = ppd_pkg::MAG_W;
    localparam int NW   = $clog2(MAX_INSERT + 1);
    localparam int PW   = NW + 1;
    localparam int DS_W = PW + 1;
    localparam logic [ppd_pkg::MAXN_W-1:0] MAX_INS_V = ppd_pkg::MAXN_W'(MAX_INSERT);

    logic [ppd_pkg::MAXN_W-1:0]    r_imax;
    logic [ppd_pkg::SPC_W-1:0]     r_spacing;
    logic                          r_have_prev;
    logic signed [CB-1:0]          r_prev_x, r_prev_y, r_new_x, r_new_y;
    logic [MW-1:0]                 r_ax, r_ay;
    logic                          r_negx, r_negy;
    logic [ppd_pkg::SQ_W-1:0]      r_prod, r_sq, r_sqop;
    logic [ppd_pkg::RT_W-1:0]      r_rem;
    logic [ppd_pkg::LEN_W-1:0]     r_root;
    logic [NW-1:0]                 r_n, r_k;
    logic [ppd_pkg::ACC_W-1:0]     r_acc;
    logic [ppd_pkg::DV_W-1:0]      r_dvd;
    logic [DS_W-1:0]               r_drem;
    logic [MW-1:0]                 r_dqx, r_dqy, r_qx, r_qy;
    logic [DS_W-1:0]               r_drx, r_dry, r_rx, r_ry;
    logic [ppd_pkg::SEG_W-1:0]     r_seg;
    logic [ppd_pkg::PATH_W-1:0]    r_path;
    logic                          r_out_valid;
    ppd_pkg::t_out_word            r_out_word;

    logic signed [MW-1:0]          w_dx, w_dy;
    logic [NW-1:0]                 w_cap;
    logic [PW-1:0]                 w_parts;
    logic [DS_W-1:0]               w_d2p;
    logic [ppd_pkg::RT_W-1:0]      w_rem_sh, w_trial;
    logic [DS_W:0]                 w_dsh;
    logic                          w_dbit;
    logic [DS_W:0]                 w_sx, w_sy;
    logic                          w_wx, w_wy;
    logic [MW-1:0]                 w_qx, w_qy;
    logic signed [MW-1:0]          w_ox, w_oy;
    logic [ppd_pkg::PATH_W:0]      w_psum;
    logic [ppd_pkg::PATH_W-1:0]    w_path;
    logic [ppd_pkg::DV_W-1:0]      w_dvd_init;

    assign w_dx = MW'(i_in_word.x_coord) - MW'(r_prev_x);
    assign w_dy = MW'(i_in_word.y_coord) - MW'(r_prev_y);

    assign w_cap   = NW'((r_imax > MAX_INS_V) ? MAX_INS_V : r_imax);
    assign w_parts = PW'(r_n) + 1'b1;
    assign w_d2p   = {w_parts, 1'b0};

    // One restoring square-root step: two radicand bits enter per cycle.
    assign w_rem_sh = {r_rem[ppd_pkg::RT_W-3:0], r_sqop[ppd_pkg::SQ_W-1 -: 2]};
    assign w_trial  = {r_root, 2'b01};

    assign w_dsh  = {r_drem, r_dvd[ppd_pkg::DV_W-1]};
    assign w_dbit = (w_dsh >= {1'b0, w_d2p});

    always_comb begin
        case (i_cmd.div_sel)
            ppd_pkg::DIV_X: w_dvd_init = ppd_pkg::DV_W'({r_ax, 1'b0});
            ppd_pkg::DIV_Y: w_dvd_init = ppd_pkg::DV_W'({r_ay, 1'b0});
            default:        w_dvd_init = ppd_pkg::DV_W'({r_root, 1'b0})
                                         + ppd_pkg::DV_W'(w_parts);
        endcase
    end

    // Interpolation advances by a fixed quotient and remainder per point.
    assign w_sx = {1'b0, r_rx} + {1'b0, r_drx};
    assign w_sy = {1'b0, r_ry} + {1'b0, r_dry};
    assign w_wx = (w_sx >= {1'b0, w_d2p});
    assign w_wy = (w_sy >= {1'b0, w_d2p});
    assign w_qx = r_qx + r_dqx + MW'(w_wx);
    assign w_qy = r_qy + r_dqy + MW'(w_wy);
    assign w_ox = r_negx ? (MW'(r_prev_x) - signed'(w_qx)) : (MW'(r_prev_x) + signed'(w_qx));
    assign w_oy = r_negy ? (MW'(r_prev_y) - signed'(w_qy)) : (MW'(r_prev_y) + signed'(w_qy));

    assign w_psum = {1'b0, r_path} + (ppd_pkg::PATH_W + 1)'(r_seg);
    assign w_path = w_psum[ppd_pkg::PATH_W] ? ppd_pkg::PATH_MAX : w_psum[ppd_pkg::PATH_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_imax      <= ppd_pkg::INSERT_MAX_RST;
            r_spacing   <= ppd_pkg::SPACING_RST;
            r_have_prev <= 1'b0;
            r_prev_x    <= '0;
            r_prev_y    <= '0;
            r_path      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    ppd_pkg::CFG_INSERT_MAX: r_imax    <= i_cfg_wdata[ppd_pkg::MAXN_W-1:0];
                    ppd_pkg::CFG_SPACING:    r_spacing <= i_cfg_wdata[ppd_pkg::SPC_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.first) begin
                r_have_prev <= 1'b1;
                r_prev_x    <= r_new_x;
                r_prev_y    <= r_new_y;
            end
            if (i_cmd.emit) begin
                r_path      <= w_path;
                r_out_valid <= 1'b1;
                if (r_k == r_n) begin
                    r_prev_x <= r_new_x;
                    r_prev_y <= r_new_y;
                end
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_new_x <= i_in_word.x_coord;
            r_new_y <= i_in_word.y_coord;
            r_negx  <= w_dx[MW-1];
            r_negy  <= w_dy[MW-1];
            r_ax    <= w_dx[MW-1] ? MW'(-w_dx) : MW'(w_dx);
            r_ay    <= w_dy[MW-1] ? MW'(-w_dy) : MW'(w_dy);
        end
        if (i_cmd.first) begin
            r_n   <= '0;
            r_seg <= '0;
            r_dqx <= '0;
            r_dqy <= '0;
            r_drx <= '0;
            r_dry <= '0;
        end
        if (i_cmd.sq_x) begin
            r_prod <= r_ax * r_ax;
        end
        if (i_cmd.sq_y) begin
            r_sq   <= r_prod;
            r_prod <= r_ay * r_ay;
        end
        if (i_cmd.sq_sum) begin
            r_sqop <= r_sq + r_prod;
            r_rem  <= '0;
            r_root <= '0;
        end
        if (i_cmd.sqrt_step) begin
            r_sqop <= r_sqop << 2;
            if (w_rem_sh >= w_trial) begin
                r_rem  <= w_rem_sh - w_trial;
                r_root <= {r_root[ppd_pkg::LEN_W-2:0], 1'b1};
            end else begin
                r_rem  <= w_rem_sh;
                r_root <= {r_root[ppd_pkg::LEN_W-2:0], 1'b0};
            end
        end
        if (i_cmd.cnt_init) begin
            r_n   <= '0;
            r_acc <= ppd_pkg::ACC_W'(r_spacing);
        end
        if (i_cmd.cnt_step) begin
            r_n   <= r_n + 1'b1;
            r_acc <= r_acc + ppd_pkg::ACC_W'(r_spacing);
        end
        if (i_cmd.div_init) begin
            r_dvd  <= w_dvd_init;
            r_drem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dvd  <= {r_dvd[ppd_pkg::DV_W-2:0], w_dbit};
            r_drem <= w_dbit ? DS_W'(w_dsh - {1'b0, w_d2p}) : w_dsh[DS_W-1:0];
        end
        if (i_cmd.div_store) begin
            case (i_cmd.div_sel)
                ppd_pkg::DIV_X: begin
                    r_dqx <= r_dvd[MW-1:0];
                    r_drx <= r_drem;
                end
                ppd_pkg::DIV_Y: begin
                    r_dqy <= r_dvd[MW-1:0];
                    r_dry <= r_drem;
                end
                default: begin
                    r_seg <= (r_dvd > ppd_pkg::DV_W'(ppd_pkg::SEG_MAX))
                             ? ppd_pkg::SEG_MAX : r_dvd[ppd_pkg::SEG_W-1:0];
                end
            endcase
        end
        if (i_cmd.emit_init) begin
            r_qx <= '0;
            r_qy <= '0;
            r_rx <= DS_W'(w_parts);
            r_ry <= DS_W'(w_parts);
            r_k  <= '0;
        end
        if (i_cmd.emit) begin
            r_qx <= w_qx;
            r_qy <= w_qy;
            r_rx <= w_wx ? DS_W'(w_sx - {1'b0, w_d2p}) : w_sx[DS_W-1:0];
            r_ry <= w_wy ? DS_W'(w_sy - {1'b0, w_d2p}) : w_sy[DS_W-1:0];
            r_k  <= r_k + 1'b1;
            r_out_word.out_x          <= w_ox[CB-1:0];
            r_out_word.out_y          <= w_oy[CB-1:0];
            r_out_word.segment_length <= r_seg;
            r_out_word.path_length    <= w_path;
            r_out_word.last_of_run    <= (r_k == r_n);
        end
    end

    assign o_status.have_prev = r_have_prev;
    assign o_status.dup       = (r_ax == '0) && (r_ay == '0);
    assign o_status.cnt_done  = (r_n == w_cap) || (r_acc > ppd_pkg::ACC_W'(r_root));
    assign o_status.emit_last = (r_k == r_n);
    assign o_status.out_free  = !r_out_valid || !i_out_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ rtl/polyline_point_densifier.sv @@
// Top level of the polyline point densifier: ties the controller to the datapath.
// Depends on ppd_pkg, ppd_ctrl and ppd_datapath.
//
// Each accepted point is worked on alone. A first point gives one word once the
// output is free; a repeated point gives no word and frees the input again. For any
// other point the bit-serial square root, the counting loop that finds n, the number
// of inserted points, and three passes of the shared bit-serial divider come first,
// after which the n+1 words leave one per cycle while the output is not stalled.
// The next point is taken once the last word of a run sits in the output register.
module polyline_point_densifier #(
    parameter int MAX_INSERT = ppd_pkg::MAX_INSERT_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [ppd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ppd_pkg::CFG_W-1:0]     i_cfg_wdata,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ppd_pkg::t_in_word             i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ppd_pkg::t_out_word            o_out_word
);

    ppd_pkg::t_cmd    w_cmd;
    ppd_pkg::t_status w_status;

    ppd_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    ppd_datapath #(
        .MAX_INSERT (MAX_INSERT)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_word   (i_in_word),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word)
    );

endmodule

@@ rtl/ppd_checker.sv @@
// Port-level checks for the polyline point densifier, bound to the top level.
// Depends on ppd_pkg and polyline_point_densifier.
module ppd_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               o_in_stall,
    input logic               o_out_valid,
    input logic               i_out_stall,
    input ppd_pkg::t_out_word o_out_word
);

    // A stalled output word must hold.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    // Taking a point makes the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a point was taken");

    // While a run is still being emitted, no new point may be taken.
    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last_of_run |-> o_in_stall)
        else $error("input open in the middle of a run");

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind polyline_point_densifier ppd_checker u_ppd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
